// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the frame table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  `ASSERT_ALWAYS(lbl, clk, rst, !(expr), msg)

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

// ----- rtl/fot_pkg.sv -----
// ----------------------------------------------------------------------------
// fot_pkg
// Shared types and constants for the frame owner table.
// ----------------------------------------------------------------------------
package fot_pkg;

  // Default sizing
  localparam int FRAMES_DEF    = 32;
  localparam int PAGE_BITS_DEF = 16;
  localparam int PROC_BITS_DEF = 8;

  // Valid bits are kept in rows of this many frames
  localparam int ROW_W  = 32;
  localparam int SLOT_W = 5;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_MARK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  // Request payload
  typedef struct packed {
    op_t         op;
    logic [4:0]  frame;
    logic [15:0] vpn;
    logic [7:0]  pid;
  } req_t;

  // Result payload
  typedef struct packed {
    logic        ok;
    logic [4:0]  frame_out;
    logic        in_use;
    logic [15:0] owner_vpn;
    logic [7:0]  owner_pid;
    logic [5:0]  free_count;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture request, read first row and owner entry
    logic next_row;  // read the following valid row
    logic commit;    // write back and register the result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_alloc;
    logic count_zero;
    logic row_free;
  } stat_t;

endpackage

// ----- rtl/fot_ctrl.sv -----
// ----------------------------------------------------------------------------
// fot_ctrl
// Sequencer: accepts a request, walks valid rows for allocate, commits.
// ----------------------------------------------------------------------------
module fot_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  fot_pkg::stat_t stat,
  output fot_pkg::cmd_t  cmd
);

  typedef enum logic {
    IDLE,
    CHECK
  } state_t;

  state_t state;
  logic   finish;

  // Allocate keeps scanning until a row has a free slot or the table is full
  assign finish = !stat.is_alloc || stat.count_zero || stat.row_free;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == IDLE) && start && !busy;
    cmd.commit   = (state == CHECK) && finish;
    cmd.next_row = (state == CHECK) && !finish;
  end

  // State and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.load) begin
            state <= CHECK;
            busy  <= 1'b1;
          end
        end
        CHECK: begin
          if (finish) begin
            state <= IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/fot_datapath.sv -----
// ----------------------------------------------------------------------------
// fot_datapath
// Valid-row memory, owner memory, free counter and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fot_datapath #(
  parameter int FRAMES    = fot_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = fot_pkg::PAGE_BITS_DEF,
  parameter int PROC_BITS = fot_pkg::PROC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  fot_pkg::req_t  req,
  input  fot_pkg::cmd_t  cmd,
  output fot_pkg::stat_t stat,
  output logic           done,
  output fot_pkg::rsp_t  rsp
);

  localparam int ROW_W  = fot_pkg::ROW_W;
  localparam int SLOT_W = fot_pkg::SLOT_W;
  localparam int ROWS   = (FRAMES + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W  = ROW_AW + SLOT_W;
  localparam int FA_W   = $clog2(FRAMES);
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int OWN_W  = PAGE_BITS + PROC_BITS;

  // Storage
  logic [ROW_W-1:0] vmem [ROWS];
  logic [OWN_W-1:0] omem [FRAMES];
  logic [ROWS-1:0]  row_valid;

  // Request and read registers
  fot_pkg::req_t    req_q;
  logic [ROW_AW-1:0] row_q;
  logic [ROW_W-1:0] row_data_q;
  logic             row_ok_q;
  logic [OWN_W-1:0] own_rd_q;
  logic [CNT_W-1:0] count_q;
  fot_pkg::rsp_t    res_q;
  logic             done_q;

  // Combinational
  logic [IDX_W-1:0]  in_idx;
  logic [ROW_AW-1:0] rd_row;
  logic [ROW_W-1:0]  eff;
  logic [ROW_W-1:0]  occ;
  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] tslot;
  logic [IDX_W-1:0]  tidx;
  logic              cur_bit;
  logic              in_range;
  logic              is_alloc;
  logic [PAGE_BITS-1:0] page_new;
  logic [PROC_BITS-1:0] proc_new;
  logic [ROW_W-1:0]  row_new;
  logic              row_we;
  logic              own_we;
  logic [CNT_W-1:0]  count_next;
  fot_pkg::rsp_t     res_next;
  logic              owner_nz;

  // Read addressing: allocate starts at row zero, others at the frame's row
  assign in_idx = IDX_W'(req.frame);
  assign rd_row = cmd.load ? ((req.op == fot_pkg::OP_ALLOC) ? '0 : in_idx[IDX_W-1:SLOT_W])
                           : row_q + 1'b1;

  // Request capture and memory reads
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q    <= req;
      own_rd_q <= omem[FA_W'(in_idx)];
    end
    if (cmd.load || cmd.next_row) begin
      row_q      <= rd_row;
      row_data_q <= vmem[rd_row];
      row_ok_q   <= row_valid[rd_row];
    end
  end

  // Row contents; slots past the last frame count as taken
  always_comb begin
    eff = row_ok_q ? row_data_q : '0;
    for (int j = 0; j < ROW_W; j++) begin
      occ[j] = eff[j] || (32'({row_q, SLOT_W'(j)}) >= 32'(FRAMES));
    end
  end

  // Lowest free slot in the row
  always_comb begin
    free_slot = '0;
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (!occ[j]) free_slot = SLOT_W'(j);
    end
  end

  assign is_alloc = (req_q.op == fot_pkg::OP_ALLOC);
  assign in_range = (32'(req_q.frame) < 32'(FRAMES));
  assign tslot    = is_alloc ? free_slot : req_q.frame[SLOT_W-1:0];
  assign tidx     = {row_q, tslot};
  assign cur_bit  = eff[tslot];
  assign page_new = PAGE_BITS'(req_q.vpn);
  assign proc_new = PROC_BITS'(req_q.pid);

  assign stat.is_alloc   = is_alloc;
  assign stat.count_zero = (count_q == '0);
  assign stat.row_free   = !(&occ);

  // Operation outcome
  always_comb begin
    row_new    = eff;
    row_we     = 1'b0;
    own_we     = 1'b0;
    count_next = count_q;
    res_next   = '0;
    case (req_q.op)
      fot_pkg::OP_ALLOC: begin
        if (count_q != '0) begin
          row_new[tslot]     = 1'b1;
          row_we             = 1'b1;
          own_we             = 1'b1;
          count_next         = count_q - 1'b1;
          res_next.ok        = 1'b1;
          res_next.frame_out = 5'(tidx);
          res_next.in_use    = 1'b1;
          res_next.owner_vpn = 16'(page_new);
          res_next.owner_pid = 8'(proc_new);
        end
      end
      fot_pkg::OP_MARK: begin
        res_next.frame_out = req_q.frame;
        if (in_range) begin
          row_new[tslot]     = 1'b1;
          row_we             = 1'b1;
          own_we             = 1'b1;
          if (!cur_bit) count_next = count_q - 1'b1;
          res_next.ok        = 1'b1;
          res_next.in_use    = 1'b1;
          res_next.owner_vpn = 16'(page_new);
          res_next.owner_pid = 8'(proc_new);
        end
      end
      fot_pkg::OP_CLEAR: begin
        res_next.frame_out = req_q.frame;
        if (in_range) begin
          row_new[tslot] = 1'b0;
          row_we         = 1'b1;
          if (cur_bit) count_next = count_q + 1'b1;
          res_next.ok    = 1'b1;
        end
      end
      default: begin
        // query
        res_next.frame_out = req_q.frame;
        if (in_range) begin
          res_next.ok     = 1'b1;
          res_next.in_use = cur_bit;
          if (cur_bit) begin
            res_next.owner_vpn = 16'(own_rd_q[OWN_W-1:PROC_BITS]);
            res_next.owner_pid = 8'(own_rd_q[PROC_BITS-1:0]);
          end
        end
      end
    endcase
    res_next.free_count = 6'(count_next);
  end

  // Memory write-back and result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (row_we) vmem[row_q] <= row_new;
      if (own_we) omem[FA_W'(tidx)] <= {page_new, proc_new};
      res_q <= res_next;
    end
  end

  // Control state: row valid bits, free counter, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      count_q   <= CNT_W'(FRAMES);
      done_q    <= 1'b0;
    end else begin
      done_q <= cmd.commit;
      if (cmd.commit) begin
        count_q <= count_next;
        if (row_we) row_valid[row_q] <= 1'b1;
      end
    end
  end

  assign done = done_q;
  assign rsp  = res_q;

  // Any owner bit set in the registered result
  assign owner_nz = |{res_q.owner_vpn, res_q.owner_pid};

  // Checks
  `ASSERT_ALWAYS(a_count_range, clk, rst, count_q <= CNT_W'(FRAMES), "free count above frames")
  `ASSERT_ALWAYS(a_done_commit, clk, rst, done_q |-> $past(cmd.commit), "strobe without commit")
  `ASSERT_NEVER(a_free_owner, clk, rst, done_q && !res_q.in_use && owner_nz, "owner on free frame")
  `ASSERT_NEVER(a_cmd_excl, clk, rst, cmd.commit && (cmd.next_row || cmd.load), "conflicting commands")

endmodule

// ----- rtl/frame_owner_table.sv -----
// ----------------------------------------------------------------------------
// frame_owner_table
// Physical frame table with first-fit allocation and a running free count.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req: op, frame, vpn, pid) transfers at a rising edge with start
//   high and busy low. Ops: allocate lowest free frame, mark, clear, query.
//   Each request yields one result on rsp, flagged by done for a single cycle;
//   the receiver takes it at the end of that cycle and cannot stall.
// Timing:
//   The request edge reads the valid row and the owner entry. For mark, clear
//   and query the next edge writes back and registers the result and raises
//   done. Allocate reads one row of 32 valid bits per cycle from the valid-row
//   memory until a row has a free slot or the table is full, then commits.
//   A new request can transfer in the cycle done is shown.
// Reset:
//   rst clears the per-row valid bits (all frames free), sets the free count
//   to FRAMES and drops busy and done. Owner storage is not cleared.
// ----------------------------------------------------------------------------
module frame_owner_table #(
  parameter int FRAMES    = fot_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = fot_pkg::PAGE_BITS_DEF,
  parameter int PROC_BITS = fot_pkg::PROC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  fot_pkg::req_t req,
  output logic          done,
  output fot_pkg::rsp_t rsp
);

  fot_pkg::cmd_t  cmd;
  fot_pkg::stat_t stat;

  // Sequencer
  fot_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Storage and result path
  fot_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .PROC_BITS (PROC_BITS)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .done (done),
    .rsp  (rsp)
  );

endmodule

// ----- test/tb_frame_owner_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_owner_table
// Self-checking bench for the frame owner table. A shadow copy of the valid
// bits, owners and free count predicts every result. The sequences fill the
// table past full, drain it, and mix all four ops. The sender idles in random
// bursts, and the monitor compares each done strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_frame_owner_table;
  import fot_pkg::*;

  localparam int NFRAMES     = 32;
  localparam int ITEMS       = 1850;
  localparam int TAIL_ITEMS  = 150;
  localparam int STALL_LIMIT = 500;
  localparam int MAX_SHOWN   = 10;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req   = '0;
  logic done;
  rsp_t rsp;

  frame_owner_table dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow frame table
  logic        tbl_valid [NFRAMES];
  logic [15:0] tbl_page  [NFRAMES];
  logic [7:0]  tbl_proc  [NFRAMES];
  int          tbl_free = NFRAMES;

  req_t req_q[$];      // requests not yet transferred
  rsp_t due_rsp_q[$];  // predicted results, oldest first
  rsp_t want_rsp;

  int mismatches   = 0;
  int idle_left    = 0;
  int idle_pct     = 10;
  int xfer_cnt     = 0;
  int quiet_cycles = 0;

  // Apply one request to the shadow table and return the result it yields
  function automatic rsp_t apply_table_op(req_t r);
    rsp_t o;
    int   slot;
    o    = '0;
    slot = -1;
    case (r.op)
      OP_ALLOC: begin
        // lowest free frame wins
        for (int i = NFRAMES - 1; i >= 0; i--) begin
          if (!tbl_valid[i]) slot = i;
        end
        if (slot >= 0) begin
          tbl_valid[slot] = 1'b1;
          tbl_page[slot]  = r.vpn;
          tbl_proc[slot]  = r.pid;
          tbl_free--;
          o.ok        = 1'b1;
          o.frame_out = 5'(slot);
        end
      end
      OP_MARK: begin
        // overwriting a valid frame leaves the count alone
        if (!tbl_valid[r.frame]) begin
          tbl_valid[r.frame] = 1'b1;
          tbl_free--;
        end
        tbl_page[r.frame] = r.vpn;
        tbl_proc[r.frame] = r.pid;
      end
      OP_CLEAR: begin
        // clearing a free frame is a no-op
        if (tbl_valid[r.frame]) begin
          tbl_valid[r.frame] = 1'b0;
          tbl_free++;
        end
      end
      OP_QUERY: begin
      end
    endcase
    // 5-bit frame field never reaches past the table, so these always succeed
    if (r.op != OP_ALLOC) begin
      o.ok        = 1'b1;
      o.frame_out = r.frame;
      slot        = r.frame;
    end
    if (slot >= 0 && tbl_valid[slot]) begin
      o.in_use    = 1'b1;
      o.owner_vpn = tbl_page[slot];
      o.owner_pid = tbl_proc[slot];
    end
    o.free_count = 6'(tbl_free);
    return o;
  endfunction

  function automatic void add_req(op_t op, logic [4:0] frame, logic [15:0] vpn,
                                  logic [7:0] pid);
    req_t r;
    r.op    = op;
    r.frame = frame;
    r.vpn   = vpn;
    r.pid   = pid;
    req_q.push_back(r);
  endfunction

  function automatic void rand_req(op_t op);
    add_req(op, 5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)),
            8'($urandom_range(0, 255)));
  endfunction

  // Stimulus, reset and end of run
  initial begin
    int seg;
    int n;
    int base;
    for (int i = 0; i < NFRAMES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_page[i]  = '0;
      tbl_proc[i]  = '0;
    end

    // Directed: edges of every field, each op, free and in-use cases
    add_req(OP_QUERY, 5'd0,  16'h0000, 8'h00);
    add_req(OP_QUERY, 5'd31, 16'hffff, 8'hff);
    add_req(OP_CLEAR, 5'd5,  16'h0000, 8'h00);   // clear of a free frame
    add_req(OP_ALLOC, 5'd31, 16'h0000, 8'h00);   // frame field ignored
    add_req(OP_ALLOC, 5'd0,  16'hffff, 8'hff);
    add_req(OP_MARK,  5'd31, 16'hffff, 8'hff);   // mark of a free frame
    add_req(OP_QUERY, 5'd31, 16'h0000, 8'h00);
    add_req(OP_MARK,  5'd31, 16'h0000, 8'h00);   // owner overwrite
    add_req(OP_QUERY, 5'd31, 16'hffff, 8'hff);
    add_req(OP_MARK,  5'd2,  16'h5a5a, 8'ha5);
    add_req(OP_CLEAR, 5'd0,  16'hffff, 8'hff);
    add_req(OP_ALLOC, 5'd7,  16'h1234, 8'h56);   // reuses frame 0
    add_req(OP_QUERY, 5'd0,  16'h0000, 8'h00);
    add_req(OP_CLEAR, 5'd1,  16'h0000, 8'h00);
    add_req(OP_CLEAR, 5'd1,  16'h0000, 8'h00);
    add_req(OP_QUERY, 5'd1,  16'h0000, 8'h00);
    add_req(OP_ALLOC, 5'd0,  16'h8001, 8'h80);   // lands in frame 1
    add_req(OP_CLEAR, 5'd31, 16'h0000, 8'h00);
    add_req(OP_CLEAR, 5'd2,  16'h0000, 8'h00);
    add_req(OP_CLEAR, 5'd1,  16'h0000, 8'h00);
    add_req(OP_CLEAR, 5'd0,  16'h0000, 8'h00);
    add_req(OP_QUERY, 5'd2,  16'h0000, 8'h00);

    // Random: fill runs that overflow the table, drain sweeps, mixed traffic
    while (req_q.size() < ITEMS) begin
      seg = $urandom_range(0, 99);
      if (seg < 30) begin
        n = $urandom_range(36, 44);
        repeat (n) begin
          if ($urandom_range(0, 9) != 0) rand_req(OP_ALLOC);
          else rand_req(OP_QUERY);
        end
      end else if (seg < 55) begin
        base = $urandom_range(0, 31);
        for (int k = 0; k < NFRAMES; k++) begin
          add_req(OP_CLEAR, 5'(base + k), 16'($urandom_range(0, 65535)),
                  8'($urandom_range(0, 255)));
          if ($urandom_range(0, 7) == 0) rand_req(op_t'($urandom_range(0, 3)));
        end
      end else begin
        n = $urandom_range(20, 60);
        repeat (n) rand_req(op_t'($urandom_range(0, 3)));
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (req_q.size() == 0 && due_rsp_q.size() == 0);
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS frame_owner_table");
    end else begin
      $display("FAIL frame_owner_table");
    end
    $finish;
  end

  // Driver: hold a request until it transfers, idle in random bursts
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        due_rsp_q.push_back(apply_table_op(req_q.pop_front()));
        xfer_cnt++;
        // change idle density now and then, sometimes to none at all
        if (xfer_cnt % 100 == 0) begin
          idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
        end
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (req_q.size() > TAIL_ITEMS && $urandom_range(0, 99) < idle_pct) begin
        idle_left = $urandom_range(1, 14) - 1;
        start <= 1'b0;
      end else if (req_q.size() > 0) begin
        start <= 1'b1;
        req   <= req_q[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each done strobe is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (due_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("unexpected result at %0t: %p", $realtime, rsp);
        end
      end else begin
        want_rsp = due_rsp_q.pop_front();
        if (rsp.ok !== want_rsp.ok || rsp.frame_out !== want_rsp.frame_out ||
            rsp.in_use !== want_rsp.in_use || rsp.owner_vpn !== want_rsp.owner_vpn ||
            rsp.owner_pid !== want_rsp.owner_pid ||
            rsp.free_count !== want_rsp.free_count) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("mismatch at %0t: expected ok=%0d frame=%0d in_use=%0d vpn=%h pid=%h free=%0d",
                     $realtime, want_rsp.ok, want_rsp.frame_out, want_rsp.in_use,
                     want_rsp.owner_vpn, want_rsp.owner_pid, want_rsp.free_count);
            $display("               got      ok=%0d frame=%0d in_use=%0d vpn=%h pid=%h free=%0d",
                     rsp.ok, rsp.frame_out, rsp.in_use, rsp.owner_vpn, rsp.owner_pid,
                     rsp.free_count);
          end
        end
      end
    end
  end

  // Watchdog: too long without a transfer or a result ends the run
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL frame_owner_table");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/fot_pkg.sv
rtl/fot_ctrl.sv
rtl/fot_datapath.sv
rtl/frame_owner_table.sv
test/tb_frame_owner_table.sv
